@@ rtl/stlg_pkg.sv @@
// Shared types and constants for the sprite tile list generator.
package stlg_pkg;

  localparam int SCREEN_WIDTH  = 336;
  localparam int SCREEN_HEIGHT = 240;

  // Signed position wide enough for a wrapped 9-bit position plus a
  // seven-tile flip offset and a row step.
  localparam int POS_W = 11;
  typedef logic signed [POS_W-1:0] pos_t;

  localparam pos_t SCR_W_POS   = pos_t'(SCREEN_WIDTH);
  localparam pos_t WRAP_OFFSET = pos_t'(512);
  localparam pos_t TILE_STEP   = pos_t'(8);
  localparam pos_t LEFT_EDGE   = -pos_t'(8);

  localparam logic [9:0] SCR_W_CMP = 10'(SCREEN_WIDTH);
  localparam logic [9:0] SCR_H_CMP = 10'(SCREEN_HEIGHT);

  localparam logic [14:0] CODE_MASK = 15'h7fff;
  localparam logic [14:0] CODE_FLIP = 15'h0800;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SCROLL_X    = 2'd0;
  localparam logic [1:0] CFG_SCROLL_Y    = 2'd1;
  localparam logic [1:0] CFG_CLIP_TOP    = 2'd2;
  localparam logic [1:0] CFG_CLIP_BOTTOM = 2'd3;

  localparam logic [7:0] CLIP_BOTTOM_RESET = 8'd239;

  typedef struct packed {
    logic load;
    logic walk;
    logic flush;
  } stlg_cmd_t;

  typedef struct packed {
    logic done;
    logic pend_valid;
  } stlg_sts_t;

endpackage

@@ rtl/stlg_ctrl.sv @@
// Controller state machine sequencing load, tile walk and flush.
module stlg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  stlg_pkg::stlg_sts_t sts,
  output logic                busy,
  output stlg_pkg::stlg_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts.done) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign cmd.load  = start && (state_r == ST_IDLE);
  assign cmd.walk  = (state_r == ST_WALK);
  assign cmd.flush = (state_r == ST_FLUSH);

endmodule

@@ rtl/stlg_datapath.sv @@
// Datapath: configuration registers, position setup, tile walk and result registers.
module stlg_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  stlg_pkg::stlg_cmd_t cmd,
  output stlg_pkg::stlg_sts_t sts,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [8:0]          cfg_data,
  input  logic [15:0]         code_word,
  input  logic [15:0]         color_x_word,
  input  logic [15:0]         y_size_word,
  output logic                out_strobe,
  output logic [14:0]         out_tile_code,
  output logic [3:0]          out_palette_color,
  output logic signed [9:0]   out_screen_x,
  output logic signed [8:0]   out_screen_y,
  output logic                out_flip_h,
  output logic                out_last_tile
);

  // Configuration registers.
  logic [8:0] scroll_x_r;
  logic [8:0] scroll_y_r;
  logic [7:0] clip_top_r;
  logic [7:0] clip_bottom_r;

  // Sprite walk registers.
  logic [14:0]        code_r;
  logic [3:0]         color_r;
  logic               flip_r;
  logic [2:0]         hm1_r;
  logic [2:0]         vm1_r;
  logic [2:0]         col_r;
  logic [2:0]         row_r;
  stlg_pkg::pos_t     xstart_r;
  stlg_pkg::pos_t     sx_r;
  stlg_pkg::pos_t     sy_r;

  // One visible tile is held back so that the final one can be marked.
  logic               pend_valid_r;
  logic [14:0]        pend_code_r;
  logic [9:0]         pend_x_r;
  logic [8:0]         pend_y_r;

  logic               out_strobe_r;
  logic [14:0]        out_code_r;
  logic [3:0]         out_color_r;
  logic [9:0]         out_x_r;
  logic [8:0]         out_y_r;
  logic               out_flip_r;
  logic               out_last_r;

  // Setup of the entry's start position.
  logic [8:0]         x_in;
  logic [8:0]         y_in;
  logic [2:0]         hm1_in;
  logic [2:0]         vm1_in;
  logic [8:0]         xv;
  logic [8:0]         yv;
  stlg_pkg::pos_t     xw;
  stlg_pkg::pos_t     yw;
  stlg_pkg::pos_t     flip_off;
  stlg_pkg::pos_t     xstart_nxt;

  // Walk decisions.
  logic               row_skip;
  logic               row_below;
  logic               col_last;
  logic               row_last;
  logic               tile_vis;

  always_comb begin
    x_in   = color_x_word[15:7];
    y_in   = y_size_word[15:7];
    hm1_in = y_size_word[5:3];
    vm1_in = y_size_word[2:0];
    xv     = x_in - scroll_x_r;
    yv     = 9'd0 - scroll_y_r - y_in - {3'b000, vm1_in, 3'b000} - 9'd8;
    xw     = $signed({2'b00, xv});
    if ({1'b0, xv} >= stlg_pkg::SCR_W_CMP) begin
      xw = xw - stlg_pkg::WRAP_OFFSET;
    end
    yw     = $signed({2'b00, yv});
    if ({1'b0, yv} >= stlg_pkg::SCR_H_CMP) begin
      yw = yw - stlg_pkg::WRAP_OFFSET;
    end
    flip_off = y_size_word[6] ? $signed({5'b00000, hm1_in, 3'b000}) : stlg_pkg::pos_t'(0);
    xstart_nxt = xw + flip_off;
  end

  always_comb begin
    // A row is above the clip when its top lies at or above clip_top - 8.
    row_skip  = (sy_r + stlg_pkg::TILE_STEP) <= $signed({3'b000, clip_top_r});
    row_below = sy_r > $signed({3'b000, clip_bottom_r});
    col_last  = (col_r == hm1_r);
    row_last  = (row_r == vm1_r);
    tile_vis  = !row_skip && !row_below &&
                (sx_r > stlg_pkg::LEFT_EDGE) && (sx_r < stlg_pkg::SCR_W_POS);
  end

  assign sts.done       = row_below || ((row_skip || col_last) && row_last);
  assign sts.pend_valid = pend_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_x_r    <= '0;
      scroll_y_r    <= '0;
      clip_top_r    <= '0;
      clip_bottom_r <= stlg_pkg::CLIP_BOTTOM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        stlg_pkg::CFG_SCROLL_X:    scroll_x_r    <= cfg_data;
        stlg_pkg::CFG_SCROLL_Y:    scroll_y_r    <= cfg_data;
        stlg_pkg::CFG_CLIP_TOP:    clip_top_r    <= cfg_data[7:0];
        stlg_pkg::CFG_CLIP_BOTTOM: clip_bottom_r <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Walk payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code_r   <= (code_word[14:0] & stlg_pkg::CODE_MASK) ^ stlg_pkg::CODE_FLIP;
      color_r  <= color_x_word[3:0];
      flip_r   <= y_size_word[6];
      hm1_r    <= hm1_in;
      vm1_r    <= vm1_in;
      col_r    <= '0;
      row_r    <= '0;
      xstart_r <= xstart_nxt;
      sx_r     <= xstart_nxt;
      sy_r     <= yw;
    end else if (cmd.walk) begin
      if (row_skip) begin
        code_r <= code_r + 15'(hm1_r) + 15'd1;
        row_r  <= row_r + 3'd1;
        col_r  <= '0;
        sx_r   <= xstart_r;
        sy_r   <= sy_r + stlg_pkg::TILE_STEP;
      end else if (!row_below) begin
        code_r <= code_r + 15'd1;
        if (col_last) begin
          row_r <= row_r + 3'd1;
          col_r <= '0;
          sx_r  <= xstart_r;
          sy_r  <= sy_r + stlg_pkg::TILE_STEP;
        end else begin
          col_r <= col_r + 3'd1;
          sx_r  <= flip_r ? (sx_r - stlg_pkg::TILE_STEP) : (sx_r + stlg_pkg::TILE_STEP);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cmd.walk && tile_vis) begin
        pend_valid_r <= 1'b1;
        out_strobe_r <= pend_valid_r;
      end else if (cmd.flush) begin
        pend_valid_r <= 1'b0;
        out_strobe_r <= pend_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk && tile_vis) begin
      pend_code_r <= code_r;
      pend_x_r    <= sx_r[9:0];
      pend_y_r    <= sy_r[8:0];
    end
    if ((cmd.walk && tile_vis) || cmd.flush) begin
      out_code_r  <= pend_code_r;
      out_color_r <= color_r;
      out_x_r     <= pend_x_r;
      out_y_r     <= pend_y_r;
      out_flip_r  <= flip_r;
      out_last_r  <= cmd.flush;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_tile_code     = out_code_r;
  assign out_palette_color = out_color_r;
  assign out_screen_x      = $signed(out_x_r);
  assign out_screen_y      = $signed(out_y_r);
  assign out_flip_h        = out_flip_r;
  assign out_last_tile     = out_last_r;

endmodule

@@ rtl/sprite_tile_list_generator.sv @@
// Order: a visible tile is held back and strobed when the next visible tile or the flush
// is reached. Throughput: one tile position per cycle in the walk, and a row above the clip
// is skipped as a whole; busy stays high through the walk and the flush state.
// The last tile is strobed in the first cycle in which busy is low again.
// Reset (synchronous, rst_n low) returns to idle and loads the register reset values.
// Results are strobed for one cycle each; the receiver cannot stall.
module sprite_tile_list_generator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        in_code_word,
  input  logic [15:0]        in_color_x_word,
  input  logic [15:0]        in_y_size_word,
  output logic               out_strobe,
  output logic [14:0]        out_tile_code,
  output logic [3:0]         out_palette_color,
  output logic signed [9:0]  out_screen_x,
  output logic signed [8:0]  out_screen_y,
  output logic               out_flip_h,
  output logic               out_last_tile,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data
);

  stlg_pkg::stlg_cmd_t cmd;
  stlg_pkg::stlg_sts_t sts;

  assign cfg_ready = 1'b1;

  stlg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  stlg_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .code_word         (in_code_word),
    .color_x_word      (in_color_x_word),
    .y_size_word       (in_y_size_word),
    .out_strobe        (out_strobe),
    .out_tile_code     (out_tile_code),
    .out_palette_color (out_palette_color),
    .out_screen_x      (out_screen_x),
    .out_screen_y      (out_screen_y),
    .out_flip_h        (out_flip_h),
    .out_last_tile     (out_last_tile)
  );

`ifndef ASSERT_OFF
  // An accepted entry always makes the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted entry");

  // No tile is held over from the previous entry when a new one begins.
  a_pend_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> !sts.pend_valid)
    else $error("held tile left over at start of entry");

  // The beat marked last is never directly followed by another beat.
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_tile) |=> !out_strobe)
    else $error("result beat directly after the last tile");
`endif

endmodule
